// ----- rtl/chunked_binary_loader_parser_top_defines.svh -----
// Assertion macros for the load-record parser checker.
// Depends on nothing; the including module must provide clock and reset.
`ifndef CHUNKED_BINARY_LOADER_PARSER_TOP_DEFINES_SVH
`define CHUNKED_BINARY_LOADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define CBLP_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define CBLP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/cblp_pkg.sv -----
// Shared types and constants of the load-record stream parser.
// Used by the channel interfaces, the top level and the checker.
package cblp_pkg;

   localparam int ADDR_BITS = 16;
   localparam logic [16:0] ADDR_SPAN = 17'(64'd1 << ADDR_BITS);

   localparam logic [7:0] TYPE_DATA = 8'h00;
   localparam logic [7:0] TYPE_END  = 8'hFF;

   localparam logic [15:0] LOW_LIMIT_RESET = 16'h6100;
   localparam logic [16:0] ROM_LIMIT_RESET = 17'h0E000;

   localparam logic CSR_LOW_LIMIT = 1'b0;
   localparam logic CSR_ROM_LIMIT = 1'b1;

   typedef enum logic [2:0] {
      ST_PARSING   = 3'd0,
      ST_DONE      = 3'd1,
      ST_LOW_ADDR  = 3'd2,
      ST_ROM_WRITE = 3'd3,
      ST_TRUNCATED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_OTHER = 2'd2
   } kind_type;

   typedef enum logic [7:0] {
      PH_TYPE   = 8'b0000_0001,
      PH_LEN_HI = 8'b0000_0010,
      PH_LEN_LO = 8'b0000_0100,
      PH_ADR_HI = 8'b0000_1000,
      PH_ADR_LO = 8'b0001_0000,
      PH_DATA   = 8'b0010_0000,
      PH_SKIP   = 8'b0100_0000,
      PH_STOP   = 8'b1000_0000
   } phase_type;

endpackage

// ----- rtl/cblp_channels.sv -----
// Valid/ready channel interfaces for the stream bytes and the parse results.
// Depends on cblp_pkg for the status type.
interface cblp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface cblp_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   write_valid;
   logic [15:0]            write_address;
   logic [7:0]             write_data;
   cblp_pkg::status_type   status;
   logic [15:0]            exec_address;
   logic [16:0]            lowest_address;
   logic [16:0]            highest_address;

   modport source (output valid, output write_valid, output write_address,
                   output write_data, output status, output exec_address,
                   output lowest_address, output highest_address, input ready);
   modport sink   (input valid, input write_valid, input write_address,
                   input write_data, input status, input exec_address,
                   input lowest_address, input highest_address, output ready);
endinterface

// ----- rtl/chunked_binary_loader_parser_top.sv -----
// Load-record parser: each accepted input beat yields a registered result beat in the next cycle.
// Throughput is one beat per cycle unless a result stalls; every state register feeds its own next state.
// The result register frees itself in the cycle its beat is taken, so input waits only while a
// result beat is held off by the receiver. Reset (synchronous, active high) returns the parser
// to the record-type phase, clears the trackers (lowest address back to 65536), restores both
// limits to their defaults and empties the result register.
module chunked_binary_loader_parser_top (
   input  logic                clock,
   input  logic                reset,
   cblp_req_if.sink            req_chan,
   cblp_rsp_if.source          rsp_chan,
   input  logic                csr_write_enable,
   input  logic                csr_index,
   input  logic [16:0]         csr_write_data
);
   import cblp_pkg::*;

   // Configuration registers. The user must write them only while the parser is idle; the block does not enforce it.
   logic [15:0] low_limit_ff;
   logic [16:0] rom_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_limit_ff <= LOW_LIMIT_RESET;
         rom_limit_ff <= ROM_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_LOW_LIMIT: low_limit_ff <= csr_write_data[15:0];
            CSR_ROM_LIMIT: rom_limit_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Parser state. The hold register keeps the high byte of a length or address
   // until its low byte arrives.
   phase_type   phase_ff,    phase_in;
   kind_type    kind_ff,     kind_in;
   logic [15:0] remain_ff,   remain_in;
   logic [7:0]  hold_ff,     hold_in;
   logic [16:0] cur_addr_ff, cur_addr_in;
   logic [15:0] exec_ff,     exec_in;
   logic [16:0] min_ff,      min_in;
   logic [16:0] max_ff,      max_in;
   status_type  status_ff,   status_in;

   // Result register with its valid flag.
   logic        rsp_valid_ff;
   logic        wr_valid_ff,  wr_valid_in;
   logic [15:0] wr_addr_ff,   wr_addr_in;
   logic [7:0]  wr_data_ff,   wr_data_in;

   logic        req_accept;
   logic [15:0] word_value;
   logic [15:0] remain_dec;
   logic [16:0] addr_inc;
   logic        rom_hit;

   // A new beat is taken whenever the result register is empty or drains this cycle.
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign word_value = {hold_ff, req_chan.data_byte};
   assign remain_dec = remain_ff - 16'd1;
   assign addr_inc   = cur_addr_ff + 17'd1;
   assign rom_hit    = (cur_addr_ff >= rom_limit_ff) || (cur_addr_ff >= ADDR_SPAN);

   always_comb begin
      phase_in    = phase_ff;
      kind_in     = kind_ff;
      remain_in   = remain_ff;
      hold_in     = hold_ff;
      cur_addr_in = cur_addr_ff;
      exec_in     = exec_ff;
      min_in      = min_ff;
      max_in      = max_ff;
      status_in   = status_ff;
      wr_valid_in = 1'b0;
      wr_addr_in  = 16'd0;
      wr_data_in  = 8'd0;

      // Once stopped, every beat just reports the frozen outputs again.
      if (phase_ff != PH_STOP) begin
         if (req_chan.end_of_stream) begin
            status_in = ST_TRUNCATED;
            phase_in  = PH_STOP;
         end else begin
            case (phase_ff)
               PH_TYPE: begin
                  if (req_chan.data_byte == TYPE_DATA) begin
                     kind_in = KIND_DATA;
                  end else if (req_chan.data_byte == TYPE_END) begin
                     kind_in = KIND_END;
                  end else begin
                     kind_in = KIND_OTHER;
                  end
                  phase_in = PH_LEN_HI;
               end
               PH_LEN_HI: begin
                  hold_in  = req_chan.data_byte;
                  phase_in = PH_LEN_LO;
               end
               PH_LEN_LO: begin
                  remain_in = word_value;
                  // Skip records go straight to their payload; an empty one ends here.
                  if (kind_ff == KIND_OTHER) begin
                     phase_in = (word_value != 16'd0) ? PH_SKIP : PH_TYPE;
                  end else begin
                     phase_in = PH_ADR_HI;
                  end
               end
               PH_ADR_HI: begin
                  hold_in  = req_chan.data_byte;
                  phase_in = PH_ADR_LO;
               end
               PH_ADR_LO: begin
                  if (kind_ff == KIND_END) begin
                     exec_in   = word_value;
                     status_in = ST_DONE;
                     phase_in  = PH_STOP;
                  end else if (word_value < low_limit_ff) begin
                     status_in = ST_LOW_ADDR;
                     phase_in  = PH_STOP;
                  end else begin
                     // Even an empty data record counts toward the address range.
                     cur_addr_in = {1'b0, word_value};
                     if ({1'b0, word_value} < min_ff) begin
                        min_in = {1'b0, word_value};
                     end
                     if ({1'b0, word_value} > max_ff) begin
                        max_in = {1'b0, word_value};
                     end
                     phase_in = (remain_ff != 16'd0) ? PH_DATA : PH_TYPE;
                  end
               end
               PH_DATA: begin
                  // A write into ROM space ends parsing for good.
                  if (rom_hit) begin
                     status_in = ST_ROM_WRITE;
                     phase_in  = PH_STOP;
                  end else begin
                     wr_valid_in = 1'b1;
                     wr_addr_in  = cur_addr_ff[15:0];
                     wr_data_in  = req_chan.data_byte;
                     cur_addr_in = addr_inc;
                     if (addr_inc > max_ff) begin
                        max_in = addr_inc;
                     end
                     remain_in = remain_dec;
                     if (remain_dec == 16'd0) begin
                        phase_in = PH_TYPE;
                     end
                  end
               end
               PH_SKIP: begin
                  remain_in = remain_dec;
                  if (remain_dec == 16'd0) begin
                     phase_in = PH_TYPE;
                  end
               end
               default: begin
                  phase_in = PH_STOP;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         kind_ff     <= KIND_DATA;
         remain_ff   <= 16'd0;
         hold_ff     <= 8'd0;
         cur_addr_ff <= 17'd0;
         exec_ff     <= 16'd0;
         min_ff      <= ADDR_SPAN;
         max_ff      <= 17'd0;
         status_ff   <= ST_PARSING;
      end else if (req_accept) begin
         phase_ff    <= phase_in;
         kind_ff     <= kind_in;
         remain_ff   <= remain_in;
         hold_ff     <= hold_in;
         cur_addr_ff <= cur_addr_in;
         exec_ff     <= exec_in;
         min_ff      <= min_in;
         max_ff      <= max_in;
         status_ff   <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // The write fields need no reset; they are only seen with the valid flag.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         wr_valid_ff <= wr_valid_in;
         wr_addr_ff  <= wr_addr_in;
         wr_data_ff  <= wr_data_in;
      end
   end

   // The tracker registers only change on an accepted beat, so they double as
   // the result fields of the beat held in the result register.
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.write_valid     = wr_valid_ff;
   assign rsp_chan.write_address   = wr_addr_ff;
   assign rsp_chan.write_data      = wr_data_ff;
   assign rsp_chan.status          = status_ff;
   assign rsp_chan.exec_address    = exec_ff;
   assign rsp_chan.lowest_address  = min_ff;
   assign rsp_chan.highest_address = max_ff;

endmodule

// ----- rtl/cblp_checker.sv -----
// Port-level checker for the load-record parser, bound to the top level.
// Depends on cblp_pkg and the assertion macros header.
`include "chunked_binary_loader_parser_top_defines.svh"

module cblp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_write_valid,
   input logic [15:0]          rsp_write_address,
   input logic [7:0]           rsp_write_data,
   input cblp_pkg::status_type rsp_status,
   input logic [16:0]          rsp_lowest_address,
   input logic [16:0]          rsp_highest_address
);
   import cblp_pkg::*;

   `CBLP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_write_address) && $stable(rsp_write_data) && $stable(rsp_status), "stalled result beat changed")
   `CBLP_ASSERT_NOW(a_no_write_when_stopped, rsp_valid && rsp_write_valid, rsp_status == ST_PARSING, "write reported after parsing stopped")
   `CBLP_ASSERT_NOW(a_write_in_range, rsp_valid && rsp_write_valid, ({1'b0, rsp_write_address} >= rsp_lowest_address) && ({1'b0, rsp_write_address} < rsp_highest_address), "write outside tracked address range")
   `CBLP_ASSERT_NOW(a_ready_only_on_stall, !req_ready, rsp_valid && !rsp_ready, "input held off without a stalled result")

endmodule

bind chunked_binary_loader_parser_top cblp_checker u_cblp_checker (
   .clock               (clock),
   .reset               (reset),
   .req_ready           (req_chan.ready),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_write_valid     (rsp_chan.write_valid),
   .rsp_write_address   (rsp_chan.write_address),
   .rsp_write_data      (rsp_chan.write_data),
   .rsp_status          (rsp_chan.status),
   .rsp_lowest_address  (rsp_chan.lowest_address),
   .rsp_highest_address (rsp_chan.highest_address)
);
